[sv/swdg_pkg.sv]
// shared types, constants and crc helper for the uart write datagram unit
package swdg_pkg;

   localparam logic [7:0] SYNC_BYTE  = 8'h05;
   localparam logic [7:0] WRITE_FLAG = 8'h80;
   localparam logic [7:0] CRC_POLY   = 8'h07;

   localparam int REQ_DATA_W   = 40;
   localparam int RSP_DATA_W   = 16;
   localparam int FRAME_W      = 10;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;
   localparam int QUEUE_DEPTH  = 2;

   localparam logic [CSR_ADDR_W-1:0] CSR_NODE_ADDRESS = 3'd0;

   // datagram byte positions
   localparam logic [2:0] BYTE_NODE   = 3'd1;
   localparam logic [2:0] BYTE_REG    = 3'd2;
   localparam logic [2:0] BYTE_VAL3   = 3'd3;
   localparam logic [2:0] BYTE_VAL2   = 3'd4;
   localparam logic [2:0] BYTE_VAL1   = 3'd5;
   localparam logic [2:0] BYTE_VAL0   = 3'd6;
   localparam logic [2:0] BYTE_CRC    = 3'd7;

   typedef struct packed {
      logic [1:0]  node_address;
      logic [7:0]  reg_byte;
      logic [31:0] register_value;
   } entry_type;

   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_cur,
                                            input logic [7:0] data);
      logic [7:0] crc;
      logic [7:0] cur;
      crc = crc_cur;
      cur = data;
      for (int j = 0; j < 8; j++) begin
         if (crc[7] ^ cur[0]) begin
            crc = {crc[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[6:0], 1'b0};
         end
         cur = {1'b0, cur[7:1]};
      end
      return crc;
   endfunction

   function automatic logic [FRAME_W-1:0] frame_of(input logic [7:0] data);
      return {1'b1, data, 1'b0};
   endfunction

endpackage

[sv/swdg_front.sv]
// front stage: takes a write request and forms a datagram entry
module swdg_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [swdg_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                        node_address,
   output logic                              push_valid,
   input  logic                              push_ready,
   output swdg_pkg::entry_type               push_entry
);

   logic                valid_ff;
   logic                valid_in;
   swdg_pkg::entry_type entry_ff;
   logic                take;

   assign req_tready = !valid_ff || push_ready;
   assign take       = req_tvalid && req_tready;
   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (push_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff.node_address   <= node_address;
         entry_ff.reg_byte       <= {1'b0, req_tdata[6:0]} | swdg_pkg::WRITE_FLAG;
         entry_ff.register_value <= req_tdata[38:7];
      end
   end

endmodule

[sv/swdg_queue.sv]
// short entry queue between the front and the back
module swdg_queue #(
   parameter int DEPTH = swdg_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  swdg_pkg::entry_type push_entry,
   output logic                pop_valid,
   input  logic                pop,
   output swdg_pkg::entry_type pop_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   swdg_pkg::entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

[sv/swdg_back.sv]
// back stage: sends the eight frames of a datagram, building the crc byte by byte
module swdg_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pop_valid,
   output logic                            pop,
   input  swdg_pkg::entry_type             pop_entry,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swdg_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            rsp_tlast
);

   localparam logic [7:0] SYNC_CRC = swdg_pkg::crc8_byte(8'h00, swdg_pkg::SYNC_BYTE);

   logic                               active_ff, active_in;
   logic [2:0]                         idx_ff, idx_in;
   logic [7:0]                         crc_ff, crc_in;
   swdg_pkg::entry_type                entry_ff;
   logic                               out_valid_ff, out_valid_in;
   logic [swdg_pkg::RSP_DATA_W-1:0]    out_data_ff, out_data_in;
   logic                               out_last_ff, out_last_in;
   logic                               advance;
   logic [7:0]                         cur_byte;

   assign advance    = !out_valid_ff || rsp_tready;
   assign pop        = advance && !active_ff && pop_valid;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tlast  = out_last_ff;

   always_comb begin
      case (idx_ff)
         swdg_pkg::BYTE_NODE: cur_byte = {6'b0, entry_ff.node_address};
         swdg_pkg::BYTE_REG:  cur_byte = entry_ff.reg_byte;
         swdg_pkg::BYTE_VAL3: cur_byte = entry_ff.register_value[31:24];
         swdg_pkg::BYTE_VAL2: cur_byte = entry_ff.register_value[23:16];
         swdg_pkg::BYTE_VAL1: cur_byte = entry_ff.register_value[15:8];
         swdg_pkg::BYTE_VAL0: cur_byte = entry_ff.register_value[7:0];
         swdg_pkg::BYTE_CRC:  cur_byte = crc_ff;
         default:             cur_byte = swdg_pkg::SYNC_BYTE;
      endcase
   end

   always_comb begin
      active_in    = active_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = 1'b0;
         if (active_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = {6'b0, swdg_pkg::frame_of(cur_byte)};
            out_last_in  = (idx_ff == swdg_pkg::BYTE_CRC);
            crc_in       = swdg_pkg::crc8_byte(crc_ff, cur_byte);
            idx_in       = idx_ff + 3'd1;
            if (idx_ff == swdg_pkg::BYTE_CRC) begin
               active_in = 1'b0;
            end
         end else if (pop_valid) begin
            out_valid_in = 1'b1;
            out_data_in  = {6'b0, swdg_pkg::frame_of(swdg_pkg::SYNC_BYTE)};
            out_last_in  = 1'b0;
            crc_in       = SYNC_CRC;
            idx_in       = swdg_pkg::BYTE_NODE;
            active_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff      <= crc_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
      if (pop) begin
         entry_ff <= pop_entry;
      end
   end

endmodule

[sv/stepper_driver_uart_write_datagram_unit.sv]
// top level of the single-wire uart write datagram builder
//
// channel   dir   payload
// req_      in    tdata[6:0] register_address, tdata[38:7] register_value
// rsp_      out   tdata[9:0] uart_frame, tlast last_frame
// csr_      in    apb, byte address 0: node_address[1:0]
//
// each item gives eight frames; the back stage emits one byte per cycle while the result
// side does not stall, and pops a new item only after the crc frame of the current one is
// registered; an item goes from the front register via a queue slot to the back output
// register; the queue holds up to QUEUE_DEPTH items so the request side keeps flowing
// while the result side stalls; reset is synchronous and clears all control state
module stepper_driver_uart_write_datagram_unit #(
   parameter int QUEUE_DEPTH = swdg_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [swdg_pkg::REQ_DATA_W-1:0] req_tdata,   // register_address, register_value
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [swdg_pkg::RSP_DATA_W-1:0] rsp_tdata,   // uart_frame
   output logic                            rsp_tlast,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [swdg_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [swdg_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [swdg_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [1:0]          node_ff, node_in;
   logic                push_valid;
   logic                push_ready;
   swdg_pkg::entry_type push_entry;
   logic                pop_valid;
   logic                pop;
   swdg_pkg::entry_type pop_entry;
   logic                csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite &&
                       (csr_paddr == swdg_pkg::CSR_NODE_ADDRESS);
   assign node_in    = csr_write ? csr_pwdata[1:0] : node_ff;
   assign csr_prdata = (csr_paddr == swdg_pkg::CSR_NODE_ADDRESS) ?
                       {{(swdg_pkg::CSR_DATA_W-2){1'b0}}, node_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff <= 2'd0;
      end else begin
         node_ff <= node_in;
      end
   end

   swdg_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .node_address (node_ff),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_entry   (push_entry)
   );

   swdg_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry)
   );

   swdg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
